/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Each macro is clocked on the rising edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge.
`define PSE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define PSE_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSE_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* src/pse_pkg.sv */
package pse_pkg;

	// Stack geometry and value width
	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	// Fixed widths of the result fields
	localparam int DEPTH_OUT_W = 5;
	localparam int TOP_OUT_W   = 32;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Operators
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	// Stack memory access: one write and one read per cycle
	typedef struct packed {
		logic                   wr_en;
		logic [ADDR_W-1:0]      wr_addr;
		logic [VALUE_WIDTH-1:0] wr_data;
		logic [ADDR_W-1:0]      rd_addr;
	} ram_req_t;

	// Divider launch
	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [VALUE_WIDTH-1:0] divisor;
	} div_req_t;

endpackage

/* src/pse_ram.sv */
module pse_ram (
	input  logic                                clk,
	input  pse_pkg::ram_req_t                   req,
	output logic [pse_pkg::VALUE_WIDTH-1:0]     rd_data
);

	logic [pse_pkg::VALUE_WIDTH-1:0] mem [pse_pkg::STACK_DEPTH];

	// Write one entry and register one read per cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem[req.rd_addr];
	end

endmodule

/* src/pse_div.sv */
module pse_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pse_pkg::div_req_t                   req,
	output logic                                done,
	output logic [pse_pkg::VALUE_WIDTH-1:0]     quotient
);

	localparam int VW    = pse_pkg::VALUE_WIDTH;
	localparam int CNT_W = $clog2(VW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    quo_q;
	logic [VW-1:0]    den_q;
	logic             neg_q;

	logic [VW-1:0]    abs_a;
	logic [VW-1:0]    abs_b;
	logic [VW:0]      shifted;
	logic [VW:0]      diff;

	// Work on magnitudes; the sign is restored at the end
	assign abs_a = req.dividend[VW-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign abs_b = req.divisor[VW-1]  ? (~req.divisor + 1'b1)  : req.divisor;

	// One restoring step: shift in the next dividend bit, try the subtract
	assign shifted = {rem_q, quo_q[VW-1]};
	assign diff    = shifted - {1'b0, den_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(VW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient and remainder, one bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= abs_a;
			den_q <= abs_b;
			neg_q <= req.dividend[VW-1] ^ req.divisor[VW-1];
		end else if (busy_q) begin
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				quo_q <= {quo_q[VW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				quo_q <= {quo_q[VW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

/* src/postfix_stack_evaluator.sv */
// Postfix stack evaluator: one character per beat, one result beat per character.
// Digits, other characters and underflowing operators go from decode to done;
// other operators add a stack read, and / by nonzero also waits on the 32-step
// divider, which sets the slow path. A new beat is taken once the previous one
// is committed, even while its result still waits at the output.
// Reset (arst_n low) empties the stack and clears all handshake state at once.
`include "assert_macros.svh"

module postfix_stack_evaluator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           char_code,
	input  logic                                 token_start,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pse_pkg::TOP_OUT_W-1:0] top_value,
	output logic [pse_pkg::DEPTH_OUT_W-1:0]      stack_depth,
	output logic [1:0]                           status
);

	localparam int VW     = pse_pkg::VALUE_WIDTH;
	localparam int SP_W   = pse_pkg::SP_W;
	localparam int ADDR_W = pse_pkg::ADDR_W;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_READ   = 5'b00100,
		S_DIV    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                state_q;
	logic [SP_W-1:0]       sp_q;
	logic                  innum_q;
	logic                  out_valid_q;

	logic [7:0]            ch_q;
	logic                  start_q;
	pse_pkg::op_t          op_q;
	logic [VW-1:0]         top_q;

	logic [VW-1:0]         nxt_top_q;
	logic [SP_W-1:0]       nxt_sp_q;
	logic                  nxt_innum_q;
	pse_pkg::status_t      nxt_status_q;
	logic                  wr_pend_q;

	logic [pse_pkg::TOP_OUT_W-1:0]   top_out_q;
	logic [pse_pkg::DEPTH_OUT_W-1:0] depth_out_q;
	pse_pkg::status_t                status_out_q;

	pse_pkg::ram_req_t     ram_req;
	logic [VW-1:0]         rd_data;
	pse_pkg::div_req_t     div_req;
	logic                  div_done;
	logic [VW-1:0]         div_quot;

	logic                  is_digit;
	logic                  is_op;
	pse_pkg::op_t          op_dec;
	logic [7:0]            digit_off;
	logic [VW-1:0]         digit_v;
	logic [VW-1:0]         ext_v;
	logic                  extend;
	logic                  full;
	logic                  push_new;
	logic [SP_W-1:0]       sp_m1;
	logic [SP_W-1:0]       sp_m2;
	logic [VW-1:0]         alu_r;
	logic                  commit;

	// Classify the held character
	assign is_digit  = (ch_q >= pse_pkg::CH_ZERO) && (ch_q <= pse_pkg::CH_NINE);
	assign digit_off = ch_q - pse_pkg::CH_ZERO;
	assign digit_v   = {{(VW - 4){1'b0}}, digit_off[3:0]};

	always_comb begin
		is_op  = 1'b1;
		op_dec = pse_pkg::OP_ADD;
		unique case (ch_q)
			pse_pkg::CH_PLUS:  op_dec = pse_pkg::OP_ADD;
			pse_pkg::CH_MINUS: op_dec = pse_pkg::OP_SUB;
			pse_pkg::CH_STAR:  op_dec = pse_pkg::OP_MUL;
			pse_pkg::CH_SLASH: op_dec = pse_pkg::OP_DIV;
			default:           is_op  = 1'b0;
		endcase
	end

	// Digit continuation: top * 10 + digit, wrapping
	assign ext_v    = (top_q << 3) + (top_q << 1) + digit_v;
	assign extend   = !start_q && innum_q && (sp_q != '0);
	assign full     = sp_q >= SP_W'(pse_pkg::STACK_DEPTH);
	assign push_new = is_digit && !extend && !full;
	assign sp_m1    = sp_q - 1'b1;
	assign sp_m2    = sp_q - SP_W'(2);

	// Combine the entry below the top (from memory) with the top register
	always_comb begin
		case (op_q)
			pse_pkg::OP_ADD: alu_r = rd_data + top_q;
			pse_pkg::OP_SUB: alu_r = rd_data - top_q;
			pse_pkg::OP_MUL: alu_r = rd_data * top_q;
			default:         alu_r = top_q;
		endcase
	end

	assign commit = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Memory holds every value below the top; a push spills the old top.
	// Writes happen at commit, and the memory registers each read.
	assign ram_req.wr_en   = commit && wr_pend_q;
	assign ram_req.wr_addr = sp_m1[ADDR_W-1:0];
	assign ram_req.wr_data = top_q;
	assign ram_req.rd_addr = sp_m2[ADDR_W-1:0];

	assign div_req.start    = (state_q == S_READ) && (op_q == pse_pkg::OP_DIV) &&
	                          (top_q != '0);
	assign div_req.dividend = rd_data;
	assign div_req.divisor  = top_q;

	pse_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequence and stack control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sp_q         <= '0;
			innum_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			nxt_sp_q     <= '0;
			nxt_innum_q  <= 1'b0;
			nxt_status_q <= pse_pkg::ST_OK;
			wr_pend_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					nxt_sp_q    <= push_new ? sp_q + 1'b1 : sp_q;
					nxt_innum_q <= is_digit && (extend || !full);
					wr_pend_q   <= push_new && (sp_q != '0);
					if (is_digit && !extend && full) begin
						nxt_status_q <= pse_pkg::ST_OVER;
					end else if (is_op && (sp_q < SP_W'(2))) begin
						nxt_status_q <= pse_pkg::ST_UNDER;
					end else begin
						nxt_status_q <= pse_pkg::ST_OK;
					end
					if (is_op && (sp_q >= SP_W'(2))) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					if (op_q == pse_pkg::OP_DIV) begin
						if (top_q == '0) begin
							nxt_status_q <= pse_pkg::ST_DIVZ;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						nxt_sp_q <= sp_m1;
						state_q  <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						nxt_sp_q <= sp_m1;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (commit) begin
						sp_q        <= nxt_sp_q;
						innum_q     <= nxt_innum_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: held beat, pending top, result registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			ch_q    <= char_code;
			start_q <= token_start;
		end
		if (state_q == S_DECODE) begin
			op_q <= op_dec;
			if (is_digit && extend) begin
				nxt_top_q <= ext_v;
			end else if (is_digit && !full) begin
				nxt_top_q <= digit_v;
			end else begin
				nxt_top_q <= top_q;
			end
		end
		if (state_q == S_READ && op_q != pse_pkg::OP_DIV) begin
			nxt_top_q <= alu_r;
		end
		if (state_q == S_DIV && div_done) begin
			nxt_top_q <= div_quot;
		end
		if (commit) begin
			top_q        <= nxt_top_q;
			top_out_q    <= (nxt_sp_q != '0) ? pse_pkg::TOP_OUT_W'(nxt_top_q) : '0;
			depth_out_q  <= pse_pkg::DEPTH_OUT_W'(nxt_sp_q);
			status_out_q <= nxt_status_q;
		end
	end

	assign in_ready    = state_q == S_IDLE;
	assign out_valid   = out_valid_q;
	assign top_value   = top_out_q;
	assign stack_depth = depth_out_q;
	assign status      = status_out_q;

	`PSE_ASSERT(a_sp_bound, clk, arst_n, sp_q <= SP_W'(pse_pkg::STACK_DEPTH), "stack pointer beyond depth")
	`PSE_ASSERT(a_innum_nonempty, clk, arst_n, innum_q |-> (sp_q != '0), "number in progress on empty stack")
	`PSE_NEVER(a_div_done_state, clk, arst_n, div_done && (state_q != S_DIV), "divider done outside wait")
	`PSE_ASSERT(a_sp_at_commit, clk, arst_n, (sp_q != $past(sp_q)) |-> ($past(state_q) == S_DONE), "stack pointer moved outside commit")

endmodule

/* dv/pse_checker.sv */
`timescale 1ns / 100ps

module pse_checker
	import pse_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    char_code,
	input  logic                          token_start,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [TOP_OUT_W-1:0]   top_value,
	input  logic [DEPTH_OUT_W-1:0]        stack_depth,
	input  logic [1:0]                    status,
	output int                            errors,
	output int                            outstanding
);

	typedef struct packed {
		logic signed [TOP_OUT_W-1:0] top;
		logic [DEPTH_OUT_W-1:0]      depth;
		status_t                     st;
	} calc_result_t;

	// Shadow copy of the operand stack
	logic [VALUE_WIDTH-1:0] operand_stack [STACK_DEPTH];
	int unsigned            operand_count;
	logic                   digit_run;
	calc_result_t           pending_results [$];

	task automatic report_mismatch(input string msg);
		if (errors < 100)
			$display("[%0t] result mismatch: %s", $time, msg);
		errors++;
	endtask

	// Apply one character to the shadow stack and work out the result beat
	task automatic apply_char(input logic [7:0] ch, input logic fresh,
			output calc_result_t res);
		logic [VALUE_WIDTH-1:0] lhs;
		logic [VALUE_WIDTH-1:0] rhs;
		logic [VALUE_WIDTH-1:0] acc;
		longint                 quo;
		status_t                st;
		st = ST_OK;
		acc = '0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (!fresh && digit_run && operand_count > 0) begin
				// extend the number on top
				operand_stack[operand_count-1] = operand_stack[operand_count-1] * 32'd10
					+ {24'd0, ch - CH_ZERO};
			end else if (operand_count >= STACK_DEPTH) begin
				st = ST_OVER;
				digit_run = 1'b0;
			end else begin
				operand_stack[operand_count] = {24'd0, ch - CH_ZERO};
				operand_count++;
				digit_run = 1'b1;
			end
		end else begin
			digit_run = 1'b0;
			case (ch)
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
				if (operand_count < 2) begin
					st = ST_UNDER;
				end else begin
					rhs = operand_stack[operand_count-1];
					lhs = operand_stack[operand_count-2];
					case (ch)
					CH_PLUS:  acc = lhs + rhs;
					CH_MINUS: acc = lhs - rhs;
					CH_STAR:  acc = lhs * rhs;
					default: begin
						// divide in 64 bits so that min / -1 wraps cleanly
						if (rhs == '0) begin
							st = ST_DIVZ;
						end else begin
							quo = longint'(signed'(lhs)) / longint'(signed'(rhs));
							acc = quo[VALUE_WIDTH-1:0];
						end
					end
					endcase
					if (st == ST_OK) begin
						operand_stack[operand_count-2] = acc;
						operand_count--;
					end
				end
			end
			default: ;
			endcase
		end
		res.top = (operand_count > 0) ? operand_stack[operand_count-1] : '0;
		res.depth = DEPTH_OUT_W'(operand_count);
		res.st = st;
	endtask

	// Check result beats against the oldest prediction, then predict new input beats
	always @(posedge clk or negedge arst_n) begin
		calc_result_t want;
		calc_result_t got;
		if (!arst_n) begin
			operand_count = 0;
			digit_run = 1'b0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got.top = top_value;
				got.depth = stack_depth;
				got.st = status_t'(status);
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected beat top %0d depth %0d status %0d",
						got.top, got.depth, got.st));
				end else begin
					want = pending_results.pop_front();
					if (got.top !== want.top)
						report_mismatch($sformatf("top_value got %0d expected %0d",
							got.top, want.top));
					if (got.depth !== want.depth)
						report_mismatch($sformatf("stack_depth got %0d expected %0d",
							got.depth, want.depth));
					if (got.st !== want.st)
						report_mismatch($sformatf("status got %0d expected %0d",
							got.st, want.st));
				end
			end
			if (in_valid && in_ready) begin
				apply_char(char_code, token_start, want);
				pending_results.push_back(want);
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import pse_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 250;
	localparam int TAIL_CYCLES  = 60;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HIGH  = 8'hFF;
	localparam logic [7:0] OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [7:0]                    char_code = 8'h00;
	logic                          token_start = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [TOP_OUT_W-1:0]   top_value;
	logic [DEPTH_OUT_W-1:0]        stack_depth;
	logic [1:0]                    status;

	int errors;
	int outstanding;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int beats_sent = 0;
	int depth_guess = 0;

	postfix_stack_evaluator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.token_start (token_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.top_value   (top_value),
		.stack_depth (stack_depth),
		.status      (status)
	);

	pse_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.token_start (token_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.top_value   (top_value),
		.stack_depth (stack_depth),
		.status      (status),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("postfix_stack_evaluator test failed");
		$finish;
	end

	// Drive out_ready: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_ticket) begin
			out_ready <= 1'b0;
			hold_seen <= hold_ticket;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Offer one character beat, idling first at random, and hold it until taken
	task automatic put_char(input logic [7:0] ch, input logic fresh);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		char_code <= ch;
		token_start <= fresh;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// Drop valid and wait until every predicted result has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Push a number of ndig digits, now and then breaking it with a stray token start
	task automatic put_number(input int ndig);
		for (int i = 0; i < ndig; i++)
			put_char(CH_ZERO + 8'($urandom_range(9)), i == 0 || $urandom_range(19) == 0);
		if (depth_guess < STACK_DEPTH)
			depth_guess++;
	endtask

	// One random token of a mostly well-formed expression
	task automatic put_token();
		int pick;
		int ndig;
		pick = $urandom_range(99);
		if (pick < 8) begin
			put_char(8'($urandom_range(255)), 1'($urandom_range(1)));
		end else if (pick < 11 || (depth_guess >= 2 && pick < (depth_guess >= 12 ? 65 : 52))) begin
			put_char(OP_CHARS[$urandom_range(3)], 1'($urandom_range(1)));
			if (depth_guess >= 2)
				depth_guess--;
		end else begin
			if ($urandom_range(99) < 60)
				ndig = 1;
			else if ($urandom_range(99) < 60)
				ndig = $urandom_range(2, 4);
			else
				ndig = $urandom_range(5, 12);
			put_number(ndig);
		end
		if ($urandom_range(2) == 0)
			put_char(CH_SPACE, 1'($urandom_range(1)));
	endtask

	// Fill the stack past full, then run random tokens and drain
	task automatic run_phase(input int tx_pct, input int rx_pct, input bit long_hold);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		if (long_hold)
			hold_ticket <= hold_ticket + 1;
		repeat (STACK_DEPTH + 2)
			put_char(CH_ZERO + 8'($urandom_range(9)), 1'b1);
		put_char(CH_NINE, 1'b0);
		depth_guess = STACK_DEPTH;
		beats_sent = 0;
		while (beats_sent < PHASE_ITEMS)
			put_token();
		wait_drained();
	endtask

	initial begin
		string expr;
		logic  fresh;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Underflow on empty and one-deep stacks, divide by zero, wrap to the
		// most negative value, most negative divided by minus one
		expr = "+ 9 - 0 / * 2147483648 0 1 - / +";
		fresh = 1'b1;
		for (int i = 0; i < expr.len(); i++) begin
			if (expr[i] == " ") begin
				fresh = 1'b1;
			end else begin
				put_char(expr[i], fresh);
				fresh = 1'b0;
			end
		end
		// Other bytes clear the digit run, so a following digit pushes
		put_char(CH_NUL, 1'b0);
		put_char(CH_HIGH, 1'b1);
		put_char(CH_ZERO + 8'd5, 1'b0);
		depth_guess = 2;
		wait_drained();

		run_phase(0, 0, 1'b1);
		run_phase(87, 0, 1'b0);
		run_phase(0, 87, 1'b0);
		run_phase(16, 16, 1'b0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("postfix_stack_evaluator test passed");
		else
			$display("postfix_stack_evaluator test failed");
		$finish;
	end

endmodule
